// ===== rtl/core/fpgd_pkg.sv =====
// Shared constants for the face pair geodesic distance unit.
package fpgd_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COORDS = 12;
  localparam int OUT_WIDTH = 36;
  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;
endpackage

// ===== rtl/core/fpgd_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
module fpgd_mul #(
  parameter int AW = 52
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic [2*AW-1:0] p
);
  localparam int H = (AW + 1) / 2;
  localparam int U = AW - H;

  logic [2*H-1:0] pp_ll;
  logic [H+U-1:0] pp_lh;
  logic [H+U-1:0] pp_hl;
  logic [2*U-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[H-1:0] * b[H-1:0];
      pp_lh <= a[H-1:0] * b[AW-1:H];
      pp_hl <= a[AW-1:H] * b[H-1:0];
      pp_hh <= a[AW-1:H] * b[AW-1:H];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (2*AW)'(pp_ll) + ((2*AW)'(pp_lh) << H) + ((2*AW)'(pp_hl) << H)
           + ((2*AW)'(pp_hh) << (2*H));
    end
  end
endmodule

// ===== rtl/core/fpgd_sqrt_cell.sv =====
// One digit cell of the dual-lane floor square root chain.
module fpgd_sqrt_cell #(
  parameter int RW = 52,
  parameter int PAYW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_x_a,
  input  logic [RW+1:0]   in_rem_a,
  input  logic [RW-1:0]   in_root_a,
  input  logic [2*RW-1:0] in_x_b,
  input  logic [RW+1:0]   in_rem_b,
  input  logic [RW-1:0]   in_root_b,
  input  logic [PAYW-1:0] in_pay,
  output logic            out_valid,
  output logic [2*RW-1:0] out_x_a,
  output logic [RW+1:0]   out_rem_a,
  output logic [RW-1:0]   out_root_a,
  output logic [2*RW-1:0] out_x_b,
  output logic [RW+1:0]   out_rem_b,
  output logic [RW-1:0]   out_root_b,
  output logic [PAYW-1:0] out_pay
);
  localparam int XW = 2 * RW;

  logic [RW+3:0] tr_a, tq_a, tr_b, tq_b;
  logic          ge_a, ge_b;

  always_comb begin
    tr_a = {in_rem_a, in_x_a[XW-1:XW-2]};
    tq_a = {2'b00, in_root_a, 2'b01};
    ge_a = tr_a >= tq_a;
    tr_b = {in_rem_b, in_x_b[XW-1:XW-2]};
    tq_b = {2'b00, in_root_b, 2'b01};
    ge_b = tr_b >= tq_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_a <= {in_x_a[XW-3:0], 2'b00};
      out_rem_a <= ge_a ? (RW+2)'(tr_a - tq_a) : tr_a[RW+1:0];
      out_root_a <= {in_root_a[RW-2:0], ge_a};
      out_x_b <= {in_x_b[XW-3:0], 2'b00};
      out_rem_b <= ge_b ? (RW+2)'(tr_b - tq_b) : tr_b[RW+1:0];
      out_root_b <= {in_root_b[RW-2:0], ge_b};
      out_pay <= in_pay;
    end
  end
endmodule

// ===== rtl/core/fpgd_div_cell.sv =====
// One quotient bit cell of the restoring divider chain.
module fpgd_div_cell #(
  parameter int TW = 107,
  parameter int SW = 52,
  parameter int PAYW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [TW-1:0]   in_num,
  input  logic [SW-1:0]   in_rem,
  input  logic [SW-1:0]   in_den,
  input  logic [PAYW-1:0] in_pay,
  output logic            out_valid,
  output logic [TW-1:0]   out_num,
  output logic [SW-1:0]   out_rem,
  output logic [SW-1:0]   out_den,
  output logic [PAYW-1:0] out_pay
);
  logic [SW:0] trial;
  logic        ge;

  always_comb begin
    trial = {in_rem, in_num[TW-1]};
    ge = trial >= {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num <= {in_num[TW-2:0], ge};
      out_rem <= ge ? SW'(trial - {1'b0, in_den}) : trial[SW-1:0];
      out_den <= in_den;
      out_pay <= in_pay;
    end
  end
endmodule

// ===== rtl/core/face_pair_geodesic_distance_unit.sv =====
// Top level: squared unfolded distance between two adjacent face centers.
// Accepts one transaction per cycle, unless stalled, and returns one result per
// transaction, in order. The pipeline holds a square root cell chain and a
// divider cell chain, one cell per root bit and per quotient bit, with the
// product, sum and output stages around them; the latency is set mostly by
// those two chains. A zero-length edge or center offset gives 0 with tuser set.
// The whole pipeline stalls while a result waits at the master side.
module face_pair_geodesic_distance_unit #(
  parameter int COORD_WIDTH = fpgd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS = fpgd_pkg::FRAC_BITS_DEF,
  localparam int IN_TDATA_W = ((fpgd_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // face_a_x, face_a_y, face_a_z, face_b_x, face_b_y, face_b_z,
  // edge_start_x, edge_start_y, edge_start_z, edge_end_x, edge_end_y, edge_end_z
  input  logic [IN_TDATA_W-1:0]            s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // geo_dist_sq
  output logic [fpgd_pkg::OUT_TDATA_W-1:0] m_tdata,
  // degenerate
  output logic                             m_tuser
);
  import fpgd_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam int DOTW = PW + 2;
  localparam int CXW = PW + 1;
  localparam int RW = CXW + 1;
  localparam int XW = 2 * RW;
  localparam int TW = 2 * RW + 3;
  localparam int SQPAYW = SW + (SW + 1) + 2 * DOTW + 1;
  localparam int DVPAYW = SW + 3;
  localparam int MPW = SW + DVPAYW;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [CW-1:0] c [NUM_COORDS];
  always_comb begin
    for (int i = 0; i < NUM_COORDS; i++) begin
      c[i] = s_tdata[i*CW +: CW];
    end
  end

  logic v1, v2, v3, v4, v5, v6;
  logic signed [DW-1:0] ax [3];
  logic signed [DW-1:0] va [3];
  logic signed [DW-1:0] vb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ax[k] <= DW'(c[9+k]) - DW'(c[6+k]);
        va[k] <= DW'(c[k]) - DW'(c[6+k]);
        vb[k] <= DW'(c[3+k]) - DW'(c[6+k]);
      end
    end
  end

  logic signed [PW-1:0] pxx [3];
  logic signed [PW-1:0] paa [3];
  logic signed [PW-1:0] pbb [3];
  logic signed [PW-1:0] pda [3];
  logic signed [PW-1:0] pdb [3];
  logic signed [PW-1:0] pca [6];
  logic signed [PW-1:0] pcb [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pxx[k] <= ax[k] * ax[k];
        paa[k] <= va[k] * va[k];
        pbb[k] <= vb[k] * vb[k];
        pda[k] <= va[k] * ax[k];
        pdb[k] <= vb[k] * ax[k];
      end
      pca[0] <= va[1] * ax[2];
      pca[1] <= va[2] * ax[1];
      pca[2] <= va[2] * ax[0];
      pca[3] <= va[0] * ax[2];
      pca[4] <= va[0] * ax[1];
      pca[5] <= va[1] * ax[0];
      pcb[0] <= vb[1] * ax[2];
      pcb[1] <= vb[2] * ax[1];
      pcb[2] <= vb[2] * ax[0];
      pcb[3] <= vb[0] * ax[2];
      pcb[4] <= vb[0] * ax[1];
      pcb[5] <= vb[1] * ax[0];
    end
  end

  logic [SW-1:0] len2_3, sa_3, sb_3;
  logic signed [DOTW-1:0] da_3, db_3;
  logic signed [CXW-1:0] xa [3];
  logic signed [CXW-1:0] xb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      len2_3 <= SW'(pxx[0]) + SW'(pxx[1]) + SW'(pxx[2]);
      sa_3 <= SW'(paa[0]) + SW'(paa[1]) + SW'(paa[2]);
      sb_3 <= SW'(pbb[0]) + SW'(pbb[1]) + SW'(pbb[2]);
      da_3 <= DOTW'(pda[0]) + DOTW'(pda[1]) + DOTW'(pda[2]);
      db_3 <= DOTW'(pdb[0]) + DOTW'(pdb[1]) + DOTW'(pdb[2]);
      for (int k = 0; k < 3; k++) begin
        xa[k] <= CXW'(pca[2*k]) - CXW'(pca[2*k+1]);
        xb[k] <= CXW'(pcb[2*k]) - CXW'(pcb[2*k+1]);
      end
    end
  end

  logic [CXW-1:0] xam [3];
  logic [CXW-1:0] xbm [3];
  logic [2*CXW-1:0] sqa [3];
  logic [2*CXW-1:0] sqb [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xam[k] = xa[k][CXW-1] ? CXW'(-xa[k]) : CXW'(xa[k]);
      xbm[k] = xb[k][CXW-1] ? CXW'(-xb[k]) : CXW'(xb[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_xsq
    fpgd_mul #(.AW(CXW)) u_mul_a (.clk(clk), .en(en), .a(xam[k]), .b(xam[k]), .p(sqa[k]));
    fpgd_mul #(.AW(CXW)) u_mul_b (.clk(clk), .en(en), .a(xbm[k]), .b(xbm[k]), .p(sqb[k]));
  end

  logic [SW-1:0] len2_4, sa_4, sb_4, len2_5, sa_5, sb_5;
  logic signed [DOTW-1:0] da_4, db_4, da_5, db_5;

  always_ff @(posedge clk) begin
    if (en) begin
      len2_4 <= len2_3;
      sa_4 <= sa_3;
      sb_4 <= sb_3;
      da_4 <= da_3;
      db_4 <= db_3;
      len2_5 <= len2_4;
      sa_5 <= sa_4;
      sb_5 <= sb_4;
      da_5 <= da_4;
      db_5 <= db_4;
    end
  end

  logic [XW-1:0] xsa_6, xsb_6;
  logic [SQPAYW-1:0] pay_6;

  always_ff @(posedge clk) begin
    if (en) begin
      xsa_6 <= XW'(sqa[0]) + XW'(sqa[1]) + XW'(sqa[2]);
      xsb_6 <= XW'(sqb[0]) + XW'(sqb[1]) + XW'(sqb[2]);
      pay_6 <= {(len2_5 == '0) || (sa_5 == '0) || (sb_5 == '0), db_5, da_5,
                (SW+1)'(sa_5) + (SW+1)'(sb_5), len2_5};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  logic            sq_v [RW+1];
  logic [XW-1:0]   sq_xa [RW+1];
  logic [RW+1:0]   sq_ra [RW+1];
  logic [RW-1:0]   sq_qa [RW+1];
  logic [XW-1:0]   sq_xb [RW+1];
  logic [RW+1:0]   sq_rb [RW+1];
  logic [RW-1:0]   sq_qb [RW+1];
  logic [SQPAYW-1:0] sq_p [RW+1];

  assign sq_v[0] = v6;
  assign sq_xa[0] = xsa_6;
  assign sq_ra[0] = '0;
  assign sq_qa[0] = '0;
  assign sq_xb[0] = xsb_6;
  assign sq_rb[0] = '0;
  assign sq_qb[0] = '0;
  assign sq_p[0] = pay_6;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    fpgd_sqrt_cell #(.RW(RW), .PAYW(SQPAYW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sq_v[i]),
      .in_x_a(sq_xa[i]), .in_rem_a(sq_ra[i]), .in_root_a(sq_qa[i]),
      .in_x_b(sq_xb[i]), .in_rem_b(sq_rb[i]), .in_root_b(sq_qb[i]),
      .in_pay(sq_p[i]),
      .out_valid(sq_v[i+1]),
      .out_x_a(sq_xa[i+1]), .out_rem_a(sq_ra[i+1]), .out_root_a(sq_qa[i+1]),
      .out_x_b(sq_xb[i+1]), .out_rem_b(sq_rb[i+1]), .out_root_b(sq_qb[i+1]),
      .out_pay(sq_p[i+1])
    );
  end

  logic [SW-1:0] len2_q;
  logic [SW:0] ssum_q;
  logic signed [DOTW-1:0] da_q, db_q;
  logic degen_q;
  logic [RW-1:0] dam, dbm;
  logic [2*RW-1:0] pdd, pcc;

  assign {degen_q, db_q, da_q, ssum_q, len2_q} = sq_p[RW];
  assign dam = da_q[DOTW-1] ? RW'(-da_q) : RW'(da_q);
  assign dbm = db_q[DOTW-1] ? RW'(-db_q) : RW'(db_q);

  fpgd_mul #(.AW(RW)) u_mul_dd (.clk(clk), .en(en), .a(dam), .b(dbm), .p(pdd));
  fpgd_mul #(.AW(RW)) u_mul_cc (.clk(clk), .en(en), .a(sq_qa[RW]), .b(sq_qb[RW]), .p(pcc));

  logic vm1, vm2, vt;
  logic [MPW-1:0] mp1, mp2;

  always_ff @(posedge clk) begin
    if (en) begin
      mp1 <= {da_q[DOTW-1] ^ db_q[DOTW-1], degen_q, ssum_q, len2_q};
      mp2 <= mp1;
    end
  end

  logic signed [TW-1:0] pa_s, t_s;
  always_comb begin
    pa_s = signed'(TW'(pdd));
    if (mp2[MPW-1]) begin
      pa_s = -pa_s;
    end
    t_s = (pa_s - signed'(TW'(pcc))) <<< 1;
  end

  logic [TW-1:0] tmag_t;
  logic [SW-1:0] len2_t;
  logic [DVPAYW-1:0] pay_t;

  always_ff @(posedge clk) begin
    if (en) begin
      tmag_t <= t_s[TW-1] ? TW'(-t_s) : TW'(t_s);
      len2_t <= mp2[SW-1:0];
      pay_t <= {t_s[TW-1], mp2[MPW-2:SW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vt <= 1'b0;
    end else if (en) begin
      vm1 <= sq_v[RW];
      vm2 <= vm1;
      vt <= vm2;
    end
  end

  logic              dv_v [TW+1];
  logic [TW-1:0]     dv_n [TW+1];
  logic [SW-1:0]     dv_r [TW+1];
  logic [SW-1:0]     dv_d [TW+1];
  logic [DVPAYW-1:0] dv_p [TW+1];

  assign dv_v[0] = vt;
  assign dv_n[0] = tmag_t;
  assign dv_r[0] = '0;
  assign dv_d[0] = len2_t;
  assign dv_p[0] = pay_t;

  for (genvar i = 0; i < TW; i++) begin : g_div
    fpgd_div_cell #(.TW(TW), .SW(SW), .PAYW(DVPAYW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv_v[i]), .in_num(dv_n[i]), .in_rem(dv_r[i]),
      .in_den(dv_d[i]), .in_pay(dv_p[i]),
      .out_valid(dv_v[i+1]), .out_num(dv_n[i+1]), .out_rem(dv_r[i+1]),
      .out_den(dv_d[i+1]), .out_pay(dv_p[i+1])
    );
  end

  logic tneg_f, degen_f;
  logic [SW:0] ssum_f;
  logic [TW+1:0] r_f, rsh_f;
  logic [OUT_WIDTH-1:0] res_f;

  always_comb begin
    {tneg_f, degen_f, ssum_f} = dv_p[TW];
    if (tneg_f) begin
      r_f = (TW+2)'(ssum_f) + {2'b00, dv_n[TW]};
    end else begin
      r_f = (TW+2)'(ssum_f) - {2'b00, dv_n[TW]};
    end
    if (r_f[TW+1]) begin
      r_f = '0;
    end
    rsh_f = r_f >> FRAC_BITS;
    if ((rsh_f >> OUT_WIDTH) != '0) begin
      res_f = '1;
    end else begin
      res_f = rsh_f[OUT_WIDTH-1:0];
    end
    if (degen_f) begin
      res_f = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_TDATA_W'(res_f);
      m_tuser <= degen_f;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result with nonzero distance");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_v[TW]) && $stable(sq_v[RW]))
    else $error("pipeline advanced during stall");
`endif
endmodule

// ===== test/tb_face_pair_geodesic_distance_unit.sv =====
// Testbench for the face pair geodesic distance unit: streamed coordinates, checked results.
`timescale 1ns / 100ps

module tb_face_pair_geodesic_distance_unit;
  import fpgd_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IN_W = ((NUM_COORDS * CW + 7) / 8) * 8;
  localparam int LATENCY = 6 * CW + 25;
  localparam int CYCLE_LIMIT = 1500000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    logic [OUT_WIDTH-1:0] dist_sq;
    logic                 degen;
  } dist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  logic [IN_W-1:0] pending_items[$];
  dist_t expected_dists[$];
  int send_idle_pct = 30;
  int recv_idle_pct = 73;
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  face_pair_geodesic_distance_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] root, cand;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  function automatic dist_t unfold_distance(logic [IN_W-1:0] d);
    logic signed [127:0] c[12];
    logic signed [127:0] ax[3], va[3], vb[3], ka[3], kb[3];
    logic signed [127:0] len2, sa, sb, da, db, ca, cb, t, q, r;
    dist_t res;
    for (int i = 0; i < 12; i++) c[i] = coord_t'(d[i*CW +: CW]);
    for (int i = 0; i < 3; i++) begin
      ax[i] = c[9+i] - c[6+i];
      va[i] = c[i] - c[6+i];
      vb[i] = c[3+i] - c[6+i];
    end
    len2 = ax[0]*ax[0] + ax[1]*ax[1] + ax[2]*ax[2];
    sa = va[0]*va[0] + va[1]*va[1] + va[2]*va[2];
    sb = vb[0]*vb[0] + vb[1]*vb[1] + vb[2]*vb[2];
    res.dist_sq = '0;
    res.degen = 1'b1;
    if (len2 == 0 || sa == 0 || sb == 0) return res;
    da = va[0]*ax[0] + va[1]*ax[1] + va[2]*ax[2];
    db = vb[0]*ax[0] + vb[1]*ax[1] + vb[2]*ax[2];
    ka[0] = va[1]*ax[2] - va[2]*ax[1];
    ka[1] = va[2]*ax[0] - va[0]*ax[2];
    ka[2] = va[0]*ax[1] - va[1]*ax[0];
    kb[0] = vb[1]*ax[2] - vb[2]*ax[1];
    kb[1] = vb[2]*ax[0] - vb[0]*ax[2];
    kb[2] = vb[0]*ax[1] - vb[1]*ax[0];
    ca = isqrt(ka[0]*ka[0] + ka[1]*ka[1] + ka[2]*ka[2]);
    cb = isqrt(kb[0]*kb[0] + kb[1]*kb[1] + kb[2]*kb[2]);
    t = 2 * (da*db - ca*cb);
    q = (t < 0) ? -((-t) / len2) : t / len2;
    r = sa + sb - q;
    if (r < 0) r = 0;
    r = r >>> FB;
    res.degen = 1'b0;
    res.dist_sq = (r > ((128'd1 << OUT_WIDTH) - 1)) ? '1 : r[OUT_WIDTH-1:0];
    return res;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8191)) - 4096;
      default: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endcase
  endfunction

  task automatic push_item(coord_t c[12]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 12; i++) d[i*CW +: CW] = c[i];
    pending_items.push_back(d);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      logic [IN_W-1:0] nxt;
      if (s_tvalid && s_tready) void'(pending_items.pop_front());
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items[0];
          s_tdata <= nxt;
          s_tvalid <= 1'b1;
          expected_dists.push_back(unfold_distance(nxt));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      dist_t exp_d;
      if (expected_dists.size() == 0) begin
        $display("%0t unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
        errors <= errors + 1;
      end else begin
        exp_d = expected_dists.pop_front();
        if (m_tdata[OUT_WIDTH-1:0] !== exp_d.dist_sq || m_tuser !== exp_d.degen) begin
          $display("%0t mismatch expected dist=%h degen=%b actual dist=%h degen=%b", $time,
                   exp_d.dist_sq, exp_d.degen, m_tdata[OUT_WIDTH-1:0], m_tuser);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    coord_t c[12];
    int mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, degenerate edge and offsets, flat and folded pairs
    for (int i = 0; i < 12; i++) c[i] = {1'b1, {(CW-1){1'b0}}};
    push_item(c);
    for (int i = 0; i < 12; i++) c[i] = {1'b0, {(CW-1){1'b1}}};
    push_item(c);
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    push_item(c);
    for (int i = 0; i < 12; i++) c[i] = 0;
    c[9] = 24'sh10000; c[1] = 24'sh10000; c[4] = -24'sh10000;
    push_item(c);
    c[4] = 24'sh10000;
    push_item(c);
    c[9] = 0;
    push_item(c);
    c[9] = 24'sh10000; c[1] = 0;
    push_item(c);
    c[1] = 24'sh10000; c[4] = 0;
    push_item(c);
    for (int i = 0; i < 12; i++) c[i] = 0;
    c[0] = {1'b1, {(CW-1){1'b0}}}; c[4] = {1'b0, {(CW-1){1'b1}}};
    c[9] = 1; c[11] = {1'b0, {(CW-1){1'b1}}};
    push_item(c);
    for (int i = 0; i < 12; i++) c[i] = 0;
    c[1] = 1; c[5] = -1; c[10] = 1;
    push_item(c);
    for (int k = 0; k < 1650; k++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++)
        c[i] = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : $urandom_range(0, 2)));
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
          1: for (int i = 0; i < 3; i++) c[i] = c[6+i];
          default: for (int i = 0; i < 3; i++) c[3+i] = c[6+i];
        endcase
      end
      push_item(c);
      if (k == 550) wait (pending_items.size() <= 1100) ;
    end
    wait (pending_items.size() < 1100);
    send_idle_pct = 73;
    recv_idle_pct = 30;
    wait (pending_items.size() < 550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_items.size() == 0 && !s_tvalid && expected_dists.size() == 0);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_dists.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/fpgd_pkg.sv
rtl/core/fpgd_mul.sv
rtl/core/fpgd_sqrt_cell.sv
rtl/core/fpgd_div_cell.sv
rtl/core/face_pair_geodesic_distance_unit.sv
test/tb_face_pair_geodesic_distance_unit.sv
